[src/accel_calibrate_move_flip_detect_top_assert.svh]
// Assertion macros for the accelerometer movement and flip detector.
// Used by the top level only; depends on nothing else.
`ifndef ACCEL_CALIBRATE_MOVE_FLIP_DETECT_TOP_ASSERT_SVH
`define ACCEL_CALIBRATE_MOVE_FLIP_DETECT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACMFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACMFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/acmfd_pkg.sv]
// Shared widths, register codes, types and saturation helper for the
// accelerometer movement and flip detector. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package acmfd_pkg;

   localparam int SAMPLES_PER_BLOCK = 100;
   localparam int SAMPLE_W = 12;
   localparam int SUM_W = 20;
   localparam int WIDE_W = SUM_W + 2;
   localparam int THR_W = 19;
   localparam int ONE_G_W = 11;
   localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK + 1);
   localparam int PROD_W = ONE_G_W + CNT_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 19;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [CSR_INDEX_W-1:0] REG_DEADZONE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FLIP_THR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_G = 2'd2;

   localparam logic [THR_W-1:0] DEADZONE_RESET = 19'd1045;
   localparam logic [THR_W-1:0] FLIP_THR_RESET = 19'd52245;
   localparam logic [ONE_G_W-1:0] ONE_G_RESET = 11'd1024;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic [THR_W-1:0] deadzone;
      logic [THR_W-1:0] flip_thr;
      logic [ONE_G_W-1:0] one_g;
   } cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0] z_sum;
      logic [SUM_W-1:0] y_sum;
      logic [SUM_W-1:0] x_sum;
      logic in_calibration;
      logic calibration_done;
      logic block_done;
      logic moved;
      logic flipped;
   } rsp_type;

   function automatic wide_type widen(input sum_type v);
      return $signed({{(WIDE_W - SUM_W){v[SUM_W-1]}}, v});
   endfunction

   function automatic sum_type sat_sum(input wide_type v);
      logic hi_same;
      hi_same = (v[WIDE_W-1:SUM_W-1] == {(WIDE_W - SUM_W + 1){v[WIDE_W-1]}});
      if (hi_same) begin
         return v[SUM_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return $signed({1'b1, {(SUM_W - 1){1'b0}}});
      end else begin
         return $signed({1'b0, {(SUM_W - 1){1'b1}}});
      end
   endfunction

endpackage

`default_nettype wire

[src/accel_calibrate_move_flip_detect_top.sv]
// A result is written to the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while req_tready is high, in a single registered pass.
// A request is taken while the output register is empty or being emptied in that cycle.
// Reset (synchronous, active high) restarts calibration, clears all sums and the
// sample count, empties the output register and restores the register defaults.
// Depends on acmfd_pkg, acmfd_csr, acmfd_accum and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "accel_calibrate_move_flip_detect_top_assert.svh"

module accel_calibrate_move_flip_detect_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // sample_x [11:0], sample_y [23:12], sample_z [35:24], zero fill above
   input  wire logic [acmfd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // flipped [0], moved [1], block_done [2], calibration_done [3],
   // in_calibration [4], accel_x_sum [24:5], accel_y_sum [44:25],
   // accel_z_sum [64:45], zero fill above
   output logic [acmfd_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                 csr_we,
   input  wire logic [acmfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [acmfd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SW = acmfd_pkg::SAMPLE_W;

   acmfd_pkg::cfg_type cfg;
   acmfd_pkg::sample_type sample [3];
   acmfd_pkg::rsp_type result;
   acmfd_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign sample[0] = req_tdata[SW-1:0];
   assign sample[1] = req_tdata[2*SW-1:SW];
   assign sample[2] = req_tdata[3*SW-1:2*SW];

   acmfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   acmfd_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .sample (sample),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      rsp_in = req_accept ? result : rsp_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(acmfd_pkg::RSP_DATA_W - $bits(acmfd_pkg::rsp_type)){1'b0}}, rsp_ff};

   `ACMFD_ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, rsp_valid_ff, "accepted request did not fill the output register")
   `ACMFD_ASSERT_NOW(a_flip_needs_move, clock, reset, rsp_valid_ff && rsp_ff.flipped, rsp_ff.moved && rsp_ff.block_done, "flip reported without a moved block")
   `ACMFD_ASSERT_NOW(a_done_exclusive, clock, reset, rsp_valid_ff && rsp_ff.calibration_done, rsp_ff.in_calibration && !rsp_ff.block_done, "calibration end and block end reported together")

endmodule

`default_nettype wire

[src/acmfd_csr.sv]
// Configuration registers: deadzone, flip threshold and counts per g.
// Depends on acmfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acmfd_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [acmfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [acmfd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output acmfd_pkg::cfg_type                        cfg
);

   acmfd_pkg::cfg_type cfg_ff;
   acmfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            acmfd_pkg::REG_DEADZONE: cfg_in.deadzone = csr_wdata[acmfd_pkg::THR_W-1:0];
            acmfd_pkg::REG_FLIP_THR: cfg_in.flip_thr = csr_wdata[acmfd_pkg::THR_W-1:0];
            acmfd_pkg::REG_ONE_G:    cfg_in.one_g = csr_wdata[acmfd_pkg::ONE_G_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadzone <= acmfd_pkg::DEADZONE_RESET;
         cfg_ff.flip_thr <= acmfd_pkg::FLIP_THR_RESET;
         cfg_ff.one_g <= acmfd_pkg::ONE_G_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/acmfd_judge.sv]
// Movement and flip decision for one finished block sum.
// Depends on acmfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acmfd_judge (
   input  wire acmfd_pkg::sum_type  blk [3],
   input  wire acmfd_pkg::sum_type  last [3],
   input  wire acmfd_pkg::cfg_type  cfg,
   output logic                     moved,
   output logic                     flipped
);

   acmfd_pkg::wide_type diff [3];
   logic [acmfd_pkg::WIDE_W-1:0] diff_mag [3];
   logic [acmfd_pkg::WIDE_W-1:0] blk_mag [2];
   logic [2:0] over_dead;
   logic [1:0] over_flip;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i] = acmfd_pkg::widen(blk[i]) - acmfd_pkg::widen(last[i]);
         diff_mag[i] = diff[i][acmfd_pkg::WIDE_W-1] ? -diff[i] : diff[i];
         over_dead[i] = diff_mag[i] >
            {{(acmfd_pkg::WIDE_W - acmfd_pkg::THR_W){1'b0}}, cfg.deadzone};
      end
      for (int i = 0; i < 2; i++) begin
         blk_mag[i] = blk[i][acmfd_pkg::SUM_W-1] ? -acmfd_pkg::widen(blk[i])
                                                  : acmfd_pkg::widen(blk[i]);
         over_flip[i] = blk_mag[i] >
            {{(acmfd_pkg::WIDE_W - acmfd_pkg::THR_W){1'b0}}, cfg.flip_thr};
      end
      moved = |over_dead;
      flipped = moved && (|over_flip);
   end

endmodule

`default_nettype wire

[src/acmfd_accum.sv]
// Calibration and block accumulation state, updated once per accepted
// request, and the result it produces. Depends on acmfd_pkg and acmfd_judge.
`timescale 1ns / 1ps
`default_nettype none

module acmfd_accum (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire acmfd_pkg::sample_type sample [3],
   input  wire acmfd_pkg::cfg_type    cfg,
   output acmfd_pkg::rsp_type         result
);

   logic calibrating_ff, calibrating_in;
   logic [acmfd_pkg::CNT_W-1:0] count_ff, count_in;
   acmfd_pkg::sum_type ground_ff [3];
   acmfd_pkg::sum_type ground_in [3];
   acmfd_pkg::sum_type running_ff [3];
   acmfd_pkg::sum_type running_in [3];
   acmfd_pkg::sum_type last_ff [3];
   acmfd_pkg::sum_type last_in [3];
   acmfd_pkg::sum_type blk [3];
   acmfd_pkg::sum_type sample_add [3];
   logic [acmfd_pkg::PROD_W-1:0] g_removal;
   acmfd_pkg::sum_type ground_z_final;
   logic block_full;
   logic moved, flipped;

   assign block_full = (count_ff >= acmfd_pkg::CNT_W'(acmfd_pkg::SAMPLES_PER_BLOCK));
   assign g_removal = acmfd_pkg::PROD_W'(cfg.one_g) *
                      acmfd_pkg::PROD_W'(acmfd_pkg::SAMPLES_PER_BLOCK);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sample_add[i] = acmfd_pkg::sat_sum(
            acmfd_pkg::widen(calibrating_ff ? ground_ff[i] : running_ff[i]) +
            $signed({{(acmfd_pkg::WIDE_W - acmfd_pkg::SAMPLE_W){sample[i][acmfd_pkg::SAMPLE_W-1]}},
                     sample[i]}));
         blk[i] = acmfd_pkg::sat_sum(acmfd_pkg::widen(running_ff[i]) -
                                     acmfd_pkg::widen(ground_ff[i]));
      end
      ground_z_final = acmfd_pkg::sat_sum(acmfd_pkg::widen(ground_ff[2]) -
         $signed({{(acmfd_pkg::WIDE_W - acmfd_pkg::PROD_W){1'b0}}, g_removal}));
   end

   acmfd_judge u_judge (
      .blk     (blk),
      .last    (last_ff),
      .cfg     (cfg),
      .moved   (moved),
      .flipped (flipped)
   );

   always_comb begin
      calibrating_in = calibrating_ff;
      count_in = count_ff;
      ground_in = ground_ff;
      running_in = running_ff;
      last_in = last_ff;
      result = '0;
      result.in_calibration = calibrating_ff;
      if (calibrating_ff) begin
         if (!block_full) begin
            ground_in = sample_add;
            count_in = count_ff + 1'b1;
         end else begin
            ground_in[2] = ground_z_final;
            count_in = '0;
            calibrating_in = 1'b0;
            result.calibration_done = 1'b1;
         end
      end else begin
         if (!block_full) begin
            running_in = sample_add;
            count_in = count_ff + 1'b1;
         end else begin
            last_in = blk;
            for (int i = 0; i < 3; i++) begin
               running_in[i] = '0;
            end
            count_in = '0;
            result.block_done = 1'b1;
            result.moved = moved;
            result.flipped = flipped;
         end
      end
      result.x_sum = last_in[0];
      result.y_sum = last_in[1];
      result.z_sum = last_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrating_ff <= 1'b1;
         count_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            ground_ff[i] <= '0;
            running_ff[i] <= '0;
            last_ff[i] <= '0;
         end
      end else if (accept) begin
         calibrating_ff <= calibrating_in;
         count_ff <= count_in;
         ground_ff <= ground_in;
         running_ff <= running_in;
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire
